>>> rtl/nau_pkg.sv
// ----------------------------------------------------------------------------
// nau_pkg
// Shared types, constants and the elaboration-time tanh knot tables of the
// activation unit.
// ----------------------------------------------------------------------------
package nau_pkg;

  localparam int DATA_W        = 16;
  localparam int FRAC_BITS     = 12;
  localparam int TABLE_ENTRIES = 256;
  localparam int TAB_AW        = $clog2(TABLE_ENTRIES);
  localparam int TQ            = 30;
  localparam int DIFF_W        = 26;
  localparam int TAYLOR_TERMS  = 24;
  // interpolation fraction bits once tanh arguments are doubled onto the sigmoid grid
  localparam int FR_W          = FRAC_BITS + 4 - TAB_AW;
  localparam int IDX_W         = DATA_W + 1 - FR_W;
  localparam int PROD_W        = 32;
  localparam int DR_W          = PROD_W - FRAC_BITS;
  localparam int T_W           = TQ + 1;
  localparam int SUM_W         = 24;

  localparam logic [63:0] TONE = 64'd1 << TQ;

  typedef enum logic [1:0] {
    FN_LINEAR  = 2'd0,
    FN_SIGMOID = 2'd1,
    FN_RELU    = 2'd2,
    FN_TANH    = 2'd3
  } func_e;

  typedef enum logic {
    KIND_FWD   = 1'b0,
    KIND_DERIV = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e kind;
    func_e func;
    logic  neg;
    logic  pos;
  } ctrl_t;

  typedef logic [TABLE_ENTRIES:0][TQ-1:0]       knot_tab_t;
  typedef logic [TABLE_ENTRIES-1:0][DIFF_W-1:0] diff_tab_t;

  // shift-subtract divide, used only while building the tables
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [63:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // T[k] = tanh(8k/N) = (1-e)/(1+e), e = q^k, q = exp(-16/N) by Taylor series
  function automatic knot_tab_t build_knots();
    knot_tab_t   tab;
    logic [63:0] u;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] q;
    logic [63:0] p;
    logic [63:0] den;
    tab  = '0;
    u    = ((64'd16 << TQ) + 64'(TABLE_ENTRIES / 2)) / 64'(TABLE_ENTRIES);
    sum  = TONE;
    term = TONE;
    for (int n = 1; n <= TAYLOR_TERMS; n++) begin
      term = udiv64((term * u) >> TQ, 64'(n));
      if (n[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    q = sum;
    p = TONE;
    for (int k = 1; k <= TABLE_ENTRIES; k++) begin
      p = (p * q + (TONE >> 1)) >> TQ;
      if (p > TONE) begin
        p = TONE;
      end
      den    = TONE + p;
      tab[k] = TQ'(udiv64(((TONE - p) << TQ) + (den >> 1), den));
    end
    return tab;
  endfunction

  function automatic diff_tab_t build_diffs(input knot_tab_t kn);
    diff_tab_t      tab;
    logic [TQ-1:0]  d;
    tab = '0;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      d      = (kn[k+1] >= kn[k]) ? (kn[k+1] - kn[k]) : '0;
      tab[k] = DIFF_W'(d);
    end
    return tab;
  endfunction

  localparam knot_tab_t KNOTS = build_knots();
  localparam diff_tab_t DIFFS = build_diffs(KNOTS);

  function automatic logic signed [DATA_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] maxv;
    logic signed [SUM_W-1:0] minv;
    maxv = SUM_W'(32767);
    minv = -SUM_W'(32768);
    if (v > maxv) begin
      return DATA_W'(32767);
    end else if (v < minv) begin
      return DATA_W'(32768);
    end
    return v[DATA_W-1:0];
  endfunction

endpackage

>>> rtl/neural_activation_unit_core.sv
// ----------------------------------------------------------------------------
// neural_activation_unit_core
// Throughput: one request per cycle; input, two compute stages and the output
// register advance together and hold when the output is stalled.
// Reset: asynchronous, clears all valid bits and selects the linear function.
// The tanh knot tables are constants; no clearing pass is needed.
// ----------------------------------------------------------------------------
module neural_activation_unit_core
  import nau_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     kind_i,
  input  logic signed [DATA_W-1:0] operand_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] result_o
);

  func_e                    fsel_q;
  logic                     adv;

  logic                     s0_valid_q;
  ctrl_t                    s0_ctrl_q;
  logic signed [DATA_W-1:0] s0_x_q;
  ctrl_t                    s0_ctrl_d;

  logic                     s1_valid;
  ctrl_t                    s1_ctrl;
  logic signed [DATA_W-1:0] s1_x;
  logic [TQ-1:0]            s1_lo;
  logic [DIFF_W-1:0]        s1_diff;
  logic [FR_W-1:0]          s1_fr;
  logic signed [PROD_W-1:0] s1_prod;

  // whole pipeline moves whenever the output register is free or drained
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsel_q <= FN_LINEAR;
    end else if (cfg_we_i) begin
      fsel_q <= func_e'(cfg_wdata_i);
    end
  end

  always_comb begin
    s0_ctrl_d.kind = kind_e'(kind_i);
    s0_ctrl_d.func = fsel_q;
    s0_ctrl_d.neg  = operand_i[DATA_W-1];
    s0_ctrl_d.pos  = !operand_i[DATA_W-1] && (operand_i != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (adv) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      s0_ctrl_q <= s0_ctrl_d;
      s0_x_q    <= operand_i;
    end
  end

  nau_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (s0_valid_q),
    .ctrl_i  (s0_ctrl_q),
    .x_i     (s0_x_q),
    .valid_o (s1_valid),
    .ctrl_o  (s1_ctrl),
    .x_o     (s1_x),
    .lo_o    (s1_lo),
    .diff_o  (s1_diff),
    .fr_o    (s1_fr),
    .prod_o  (s1_prod)
  );

  nau_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (s1_valid),
    .ctrl_i   (s1_ctrl),
    .x_i      (s1_x),
    .lo_i     (s1_lo),
    .diff_i   (s1_diff),
    .fr_i     (s1_fr),
    .prod_i   (s1_prod),
    .valid_o  (out_valid_o),
    .result_o (result_o)
  );

`ifndef SYNTHESIS
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> s0_valid_q && s0_x_q == $past(operand_i))
    else $error("accepted request not captured in first stage");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(s0_valid_q) && $stable(s1_valid))
    else $error("pipeline valid bits moved during a stall");
`endif

endmodule

>>> rtl/nau_front.sv
// ----------------------------------------------------------------------------
// nau_front
// Stage 1: operand magnitude, tanh knot lookup and the derivative product.
// ----------------------------------------------------------------------------
module nau_front
  import nau_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  logic                     valid_i,
  input  ctrl_t                    ctrl_i,
  input  logic signed [DATA_W-1:0] x_i,
  output logic                     valid_o,
  output ctrl_t                    ctrl_o,
  output logic signed [DATA_W-1:0] x_o,
  output logic [TQ-1:0]            lo_o,
  output logic [DIFF_W-1:0]        diff_o,
  output logic [FR_W-1:0]          fr_o,
  output logic signed [PROD_W-1:0] prod_o
);

  localparam logic signed [DATA_W+1:0] ONE_X = (DATA_W+2)'(1 << FRAC_BITS);

  logic [DATA_W-1:0]         mag;
  logic [DATA_W:0]           m;
  logic [IDX_W-1:0]          idx;
  logic [TQ-1:0]             lo_d;
  logic [DIFF_W-1:0]         diff_d;
  logic signed [DATA_W+1:0]  xs;
  logic signed [DATA_W+1:0]  mb;
  logic signed [2*DATA_W+3:0] prod_full;

  logic                      valid_q;
  ctrl_t                     ctrl_q;
  logic signed [DATA_W-1:0]  x_q;
  logic [TQ-1:0]             lo_q;
  logic [DIFF_W-1:0]         diff_q;
  logic [FR_W-1:0]           fr_q;
  logic signed [PROD_W-1:0]  prod_q;

  always_comb begin
    mag = x_i[DATA_W-1] ? (~x_i + 1'b1) : x_i;
    // tanh uses |x|, sigmoid |x|/2: double tanh so both share one grid
    m   = (ctrl_i.func == FN_TANH) ? {mag, 1'b0} : {1'b0, mag};
    idx = m[DATA_W -: IDX_W];
    if (idx >= IDX_W'(TABLE_ENTRIES)) begin
      lo_d   = KNOTS[TABLE_ENTRIES];
      diff_d = '0;
    end else begin
      lo_d   = KNOTS[idx[TAB_AW-1:0]];
      diff_d = DIFFS[idx[TAB_AW-1:0]];
    end
  end

  always_comb begin
    xs        = (DATA_W+2)'(x_i);
    mb        = (ctrl_i.func == FN_SIGMOID) ? (ONE_X - xs) : xs;
    prod_full = (2*DATA_W+4)'(xs) * (2*DATA_W+4)'(mb);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      ctrl_q <= ctrl_i;
      x_q    <= x_i;
      lo_q   <= lo_d;
      diff_q <= diff_d;
      fr_q   <= m[FR_W-1:0];
      prod_q <= prod_full[PROD_W-1:0];
    end
  end

  assign valid_o = valid_q;
  assign ctrl_o  = ctrl_q;
  assign x_o     = x_q;
  assign lo_o    = lo_q;
  assign diff_o  = diff_q;
  assign fr_o    = fr_q;
  assign prod_o  = prod_q;

endmodule

>>> rtl/nau_back.sv
// ----------------------------------------------------------------------------
// nau_back
// Stage 2: interpolation and derivative rounding. Stage 3: output rounding,
// function select, saturation and the output register.
// ----------------------------------------------------------------------------
module nau_back
  import nau_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  logic                     valid_i,
  input  ctrl_t                    ctrl_i,
  input  logic signed [DATA_W-1:0] x_i,
  input  logic [TQ-1:0]            lo_i,
  input  logic [DIFF_W-1:0]        diff_i,
  input  logic [FR_W-1:0]          fr_i,
  input  logic signed [PROD_W-1:0] prod_i,
  output logic                     valid_o,
  output logic signed [DATA_W-1:0] result_o
);

  localparam int TERM_W  = DIFF_W + FR_W;
  localparam int SIG_SH  = TQ + 1 - FRAC_BITS;
  localparam int TANH_SH = TQ - FRAC_BITS;
  localparam logic signed [SUM_W-1:0] ONE_V = SUM_W'(1 << FRAC_BITS);
  localparam logic [T_W:0]            TONE_W = (T_W+1)'(TONE);

  logic [TERM_W-1:0]         term;
  logic [T_W-1:0]            t_d;
  logic signed [DR_W-1:0]    dr_d;

  logic                      s2_valid_q;
  ctrl_t                     s2_ctrl_q;
  logic signed [DATA_W-1:0]  s2_x_q;
  logic [T_W-1:0]            s2_t_q;
  logic signed [DR_W-1:0]    s2_dr_q;

  logic [T_W:0]              sig_sum;
  logic [T_W:0]              tanh_sum;
  logic signed [SUM_W-1:0]   tanh_mag;
  logic signed [SUM_W-1:0]   xv;
  logic signed [SUM_W-1:0]   drv;
  logic signed [SUM_W-1:0]   v;

  logic                      out_valid_q;
  logic signed [DATA_W-1:0]  result_q;

  // stage 2
  always_comb begin
    term = TERM_W'(diff_i) * TERM_W'(fr_i);
    t_d  = T_W'(lo_i) + T_W'((term + TERM_W'(1 << (FR_W - 1))) >> FR_W);
    dr_d = DR_W'((prod_i + PROD_W'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv_i) begin
      s2_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      s2_ctrl_q <= ctrl_i;
      s2_x_q    <= x_i;
      s2_t_q    <= t_d;
      s2_dr_q   <= dr_d;
    end
  end

  // stage 3
  always_comb begin
    sig_sum  = (s2_ctrl_q.neg ? (TONE_W - (T_W+1)'(s2_t_q)) : (TONE_W + (T_W+1)'(s2_t_q)))
             + (T_W+1)'(1 << (SIG_SH - 1));
    tanh_sum = (T_W+1)'(s2_t_q) + (T_W+1)'(1 << (TANH_SH - 1));
    tanh_mag = SUM_W'(tanh_sum >> TANH_SH);
    xv       = {{(SUM_W-DATA_W){s2_x_q[DATA_W-1]}}, s2_x_q};
    drv      = {{(SUM_W-DR_W){s2_dr_q[DR_W-1]}}, s2_dr_q};
    v        = xv;
    if (s2_ctrl_q.kind == KIND_FWD) begin
      case (s2_ctrl_q.func)
        FN_LINEAR:  v = xv;
        FN_SIGMOID: v = SUM_W'(sig_sum >> SIG_SH);
        FN_RELU:    v = s2_ctrl_q.pos ? xv : '0;
        FN_TANH:    v = s2_ctrl_q.neg ? -tanh_mag : tanh_mag;
        default:    v = xv;
      endcase
    end else begin
      case (s2_ctrl_q.func)
        FN_LINEAR:  v = ONE_V;
        FN_SIGMOID: v = drv;
        FN_RELU:    v = s2_ctrl_q.pos ? ONE_V : '0;
        FN_TANH:    v = ONE_V - drv;
        default:    v = ONE_V;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && s2_valid_q) begin
      result_q <= sat16(v);
    end
  end

  assign valid_o  = out_valid_q;
  assign result_o = result_q;

`ifndef SYNTHESIS
  a_sigmoid_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && s2_valid_q && s2_ctrl_q.kind == KIND_FWD && s2_ctrl_q.func == FN_SIGMOID
    |=> result_q >= 0 && result_q <= DATA_W'(1 << FRAC_BITS))
    else $error("sigmoid result outside [0, 1.0]");

  a_tanh_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && s2_valid_q && s2_ctrl_q.kind == KIND_FWD && s2_ctrl_q.func == FN_TANH
    |=> result_q >= -$signed(DATA_W'(1 << FRAC_BITS)) && result_q <= DATA_W'(1 << FRAC_BITS))
    else $error("tanh result outside [-1.0, 1.0]");

  a_relu_deriv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && s2_valid_q && s2_ctrl_q.kind == KIND_DERIV && s2_ctrl_q.func == FN_RELU
    |=> result_q == 0 || result_q == DATA_W'(1 << FRAC_BITS))
    else $error("relu derivative not 0 or 1.0");
`endif

endmodule
